>>> rtl/pst_pkg.sv
package pst_pkg;

   localparam int SEC_W  = 8;   // section_number / last_section_number
   localparam int SIZE_W = 9;   // table size, counts, range bounds
   localparam int VER_W  = 5;
   localparam int CMD_W  = 3;

   typedef logic [CMD_W-1:0] cmd_code_type;

   localparam cmd_code_type CMD_CHECK   = 3'd0;
   localparam cmd_code_type CMD_MARK    = 3'd1;
   localparam cmd_code_type CMD_QUERY   = 3'd2;
   localparam cmd_code_type CMD_SET_VER = 3'd3;
   localparam cmd_code_type CMD_EXPIRE  = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic load;         // latch request word, read bitmap at its section
      logic exec;         // evaluate latched command
      logic mark_step;    // one range-mark step
      logic clear_step;   // clear one bitmap entry
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mark_start;    // exec of a mark_range that has work to do
      logic mark_last;     // last read has come back, final write this cycle
      logic clear_start;   // exec of a set_version on a sized table
      logic clear_last;    // current clear is the final one
   } dp_status_type;

endpackage

>>> rtl/pst_ctrl.sv
module pst_ctrl
   import pst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_MARK,
      ST_CLEAR
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   assign dp_cmd.load       = (state_ff == ST_IDLE) && start;
   assign dp_cmd.exec       = (state_ff == ST_EXEC);
   assign dp_cmd.mark_step  = (state_ff == ST_MARK);
   assign dp_cmd.clear_step = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_INIT: begin
               // bitmap clear after reset, no result word
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EXEC: begin
               if (status.mark_start) begin
                  state_ff <= ST_MARK;
               end else if (status.clear_start) begin
                  state_ff <= ST_CLEAR;
               end else begin
                  state_ff  <= ST_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end
            end
            ST_MARK: begin
               if (status.mark_last) begin
                  state_ff  <= ST_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end
            end
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff  <= ST_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

>>> rtl/pst_datapath.sv
module pst_datapath
   import pst_pkg::*;
#(
   parameter int MAX_SECTIONS = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        dp_cmd,
   output dp_status_type     status,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [SEC_W-1:0]  req_section_number,
   input  logic [SEC_W-1:0]  req_last_section_number,
   input  logic [SIZE_W-1:0] req_range_first,
   input  logic [SIZE_W-1:0] req_range_end,
   input  logic [VER_W-1:0]  req_version,
   output logic              rsp_accepted,
   output logic              rsp_was_seen,
   output logic              rsp_range_error,
   output logic              rsp_version_differs,
   output logic              rsp_complete,
   output logic [SIZE_W-1:0] rsp_table_size,
   output logic [SIZE_W-1:0] rsp_seen_count,
   output logic [VER_W-1:0]  rsp_current_version,
   output logic              rsp_version_valid
);

   localparam int                IDX_W  = $clog2(MAX_SECTIONS);
   localparam logic [SIZE_W-1:0] MAX_SZ = SIZE_W'(MAX_SECTIONS);

   // latched request word
   cmd_code_type      cmd_ff;
   logic [SEC_W-1:0]  sec_ff;
   logic [SEC_W-1:0]  last_ff;
   logic [SIZE_W-1:0] first_ff;
   logic [SIZE_W-1:0] end_ff;
   logic [VER_W-1:0]  ver_ff;

   // seen bitmap: one registered read and one write per cycle
   logic             seen_mem [MAX_SECTIONS];
   logic             rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_data;

   // tracker state
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] count_ff, count_in;
   logic [VER_W-1:0]  cur_ver_ff, cur_ver_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [VER_W-1:0]  exp_ver_ff, exp_ver_in;
   logic              exp_valid_ff, exp_valid_in;

   // result flags and walk control
   logic              acc_ff, acc_in;
   logic              was_seen_ff, was_seen_in;
   logic              rerr_ff, rerr_in;
   logic              differs_ff, differs_in;
   logic [SIZE_W-1:0] idx_ff, idx_in;
   logic [SIZE_W-1:0] clr_end_ff, clr_end_in;

   logic [SIZE_W-1:0] sec_ext;
   logic [SIZE_W-1:0] want;
   logic [SIZE_W-1:0] idx_prev;
   logic              sec_in_map;
   logic              seen_at_sec;
   logic              range_bad;
   logic              mark_pending;

   assign sec_ext      = {1'b0, sec_ff};
   assign want         = {1'b0, last_ff} + SIZE_W'(1);
   assign sec_in_map   = sec_ext < MAX_SZ;
   assign seen_at_sec  = sec_in_map && rd_data_ff;
   assign range_bad    = end_ff > size_ff;
   assign idx_prev     = idx_ff - SIZE_W'(1);
   // once past range_first, the read issued last cycle is back in rd_data_ff
   assign mark_pending = idx_ff != first_ff;

   assign rd_addr = dp_cmd.load ? req_section_number[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   assign status.mark_start  = dp_cmd.exec && (cmd_ff == CMD_MARK) && !range_bad
                               && (first_ff < end_ff);
   assign status.mark_last   = idx_ff == end_ff;
   assign status.clear_start = dp_cmd.exec && (cmd_ff == CMD_SET_VER)
                               && (size_ff != '0);
   assign status.clear_last  = (idx_ff + SIZE_W'(1)) == clr_end_ff;

   always_comb begin
      size_in      = size_ff;
      count_in     = count_ff;
      cur_ver_in   = cur_ver_ff;
      cur_valid_in = cur_valid_ff;
      exp_ver_in   = exp_ver_ff;
      exp_valid_in = exp_valid_ff;
      acc_in       = acc_ff;
      was_seen_in  = was_seen_ff;
      rerr_in      = rerr_ff;
      differs_in   = differs_ff;
      idx_in       = idx_ff;
      clr_end_in   = clr_end_ff;
      wr_en        = 1'b0;
      wr_addr      = sec_ff[IDX_W-1:0];
      wr_data      = 1'b1;

      if (dp_cmd.exec) begin
         acc_in      = 1'b0;
         was_seen_in = 1'b0;
         rerr_in     = 1'b0;
         differs_in  = !cur_valid_ff || (ver_ff != cur_ver_ff);
         idx_in      = first_ff;
         case (cmd_ff)
            CMD_CHECK: begin
               if (count_ff == '0) begin
                  // first section sizes the table; the bitmap is empty while
                  // the count is zero
                  if ((want <= MAX_SZ) && (sec_ff <= last_ff)) begin
                     wr_en    = 1'b1;
                     size_in  = want;
                     count_in = SIZE_W'(1);
                     acc_in   = 1'b1;
                  end
               end else if ((want == size_ff) && (sec_ff <= last_ff) && sec_in_map
                            && !seen_at_sec) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + SIZE_W'(1);
                  acc_in   = 1'b1;
               end
            end
            CMD_MARK: begin
               rerr_in = range_bad;
            end
            CMD_QUERY: begin
               was_seen_in = (sec_ext < size_ff) && seen_at_sec;
            end
            CMD_SET_VER: begin
               // only entries below the old size can be set
               size_in      = '0;
               count_in     = '0;
               cur_ver_in   = ver_ff;
               cur_valid_in = 1'b1;
               idx_in       = '0;
               clr_end_in   = size_ff;
            end
            CMD_EXPIRE: begin
               if ((cur_valid_ff != exp_valid_ff) ||
                   (cur_valid_ff && (cur_ver_ff != exp_ver_ff))) begin
                  exp_ver_in   = cur_ver_ff;
                  exp_valid_in = cur_valid_ff;
                  acc_in       = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // range walk: read idx, write idx-1 from last cycle's read;
      // end never exceeds size here, so every entry written is in the table
      if (dp_cmd.mark_step) begin
         if (mark_pending && !rd_data_ff) begin
            wr_en    = 1'b1;
            wr_addr  = idx_prev[IDX_W-1:0];
            count_in = count_ff + SIZE_W'(1);
         end
         if (idx_ff != end_ff) begin
            idx_in = idx_ff + SIZE_W'(1);
         end
      end

      if (dp_cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[IDX_W-1:0];
         wr_data = 1'b0;
         idx_in  = idx_ff + SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         count_ff     <= '0;
         cur_ver_ff   <= '0;
         cur_valid_ff <= 1'b0;
         exp_ver_ff   <= '0;
         exp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         clr_end_ff   <= MAX_SZ;
      end else begin
         size_ff      <= size_in;
         count_ff     <= count_in;
         cur_ver_ff   <= cur_ver_in;
         cur_valid_ff <= cur_valid_in;
         exp_ver_ff   <= exp_ver_in;
         exp_valid_ff <= exp_valid_in;
         idx_ff       <= idx_in;
         clr_end_ff   <= clr_end_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      was_seen_ff <= was_seen_in;
      rerr_ff     <= rerr_in;
      differs_ff  <= differs_in;
      if (dp_cmd.load) begin
         cmd_ff   <= req_command;
         sec_ff   <= req_section_number;
         last_ff  <= req_last_section_number;
         first_ff <= req_range_first;
         end_ff   <= req_range_end;
         ver_ff   <= req_version;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seen_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= seen_mem[rd_addr];
   end

   assign rsp_accepted        = acc_ff;
   assign rsp_was_seen        = was_seen_ff;
   assign rsp_range_error     = rerr_ff;
   assign rsp_version_differs = differs_ff;
   assign rsp_complete        = count_ff == size_ff;
   assign rsp_table_size      = size_ff;
   assign rsp_seen_count      = count_ff;
   assign rsp_current_version = cur_ver_ff;
   assign rsp_version_valid   = cur_valid_ff;

endmodule

>>> rtl/psi_section_tracker.sv
// PSI section completion tracker.
// Request channel: req_* fields are taken at a rising edge with start high and
// busy low. Commands: check_section, mark_range, query_section, set_version,
// expire. Every command produces exactly one result word.
// Result channel: rsp_* fields are valid for the single cycle in which
// rsp_strobe is high; the receiver cannot stall, so the word must be taken then.
// Sequence: the accepting edge moves the controller into its execute state,
// which then raises rsp_strobe with the result word, except for the walks over
// the seen bitmap, which has one read and one write port:
//   mark_range, legal and non-empty: a mark state steps from range_first up to
//   range_end (reads run one entry ahead of the writes);
//   set_version on a sized table: a clear walk over it, one entry cleared a cycle.
// Issue: busy drops in the strobe cycle, so the next command can be
// accepted at the edge that takes the word.
// Reset (synchronous): clears table size, count and both version registers;
// rsp_strobe goes low, and busy stays high after reset while all MAX_SECTIONS
// bitmap entries are cleared one entry per cycle.
module psi_section_tracker
   import pst_pkg::*;
#(
   parameter int MAX_SECTIONS = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [SEC_W-1:0]  req_section_number,
   input  logic [SEC_W-1:0]  req_last_section_number,
   input  logic [SIZE_W-1:0] req_range_first,
   input  logic [SIZE_W-1:0] req_range_end,
   input  logic [VER_W-1:0]  req_version,
   output logic              rsp_strobe,
   output logic              rsp_accepted,
   output logic              rsp_was_seen,
   output logic              rsp_range_error,
   output logic              rsp_version_differs,
   output logic              rsp_complete,
   output logic [SIZE_W-1:0] rsp_table_size,
   output logic [SIZE_W-1:0] rsp_seen_count,
   output logic [VER_W-1:0]  rsp_current_version,
   output logic              rsp_version_valid
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   pst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .dp_cmd     (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pst_datapath #(
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .dp_cmd                  (dp_cmd),
      .status                  (status),
      .req_command             (req_command),
      .req_section_number      (req_section_number),
      .req_last_section_number (req_last_section_number),
      .req_range_first         (req_range_first),
      .req_range_end           (req_range_end),
      .req_version             (req_version),
      .rsp_accepted            (rsp_accepted),
      .rsp_was_seen            (rsp_was_seen),
      .rsp_range_error         (rsp_range_error),
      .rsp_version_differs     (rsp_version_differs),
      .rsp_complete            (rsp_complete),
      .rsp_table_size          (rsp_table_size),
      .rsp_seen_count          (rsp_seen_count),
      .rsp_current_version     (rsp_current_version),
      .rsp_version_valid       (rsp_version_valid)
   );

endmodule
